// File: rtl/lfe_pkg.sv
// Package for the light fade envelope core: widths, lane indexes and the
// structs that travel between the setup stage, the lane evaluators and the dimmer.
// No dependencies.
package lfe_pkg;

   // Field widths.
   localparam int TW = 32;              // time left, signed
   localparam int QW = 16;              // radius, colour and quotient width
   localparam int DW = QW + 1;          // fraction numerator and denominator width
   localparam int PW = QW + DW;         // product width
   localparam int XW = TW + 2;          // signed width for time differences
   localparam int FW = 3;               // mode flag width

   // Mode flag bits.
   localparam int FLAG_EXPAND = 0;
   localparam int FLAG_SHRINK = 1;
   localparam int FLAG_FLASH  = 2;

   // Lane assignment: radius first, then the three colour channels.
   localparam int LANES    = 4;
   localparam int LANE_RAD = 0;
   localparam int LANE_R   = 1;
   localparam int LANE_G   = 2;
   localparam int LANE_B   = 3;

   // Lane evaluator depth: one multiply stage, one stage per quotient bit, one add stage.
   localparam int DIV_STEPS = QW;
   localparam int MAD_DEPTH = DIV_STEPS + 2;

   // One lane computes base +/- (mul_x * mul_y) / den.
   typedef struct packed {
      logic [QW-1:0] base;
      logic          neg;
      logic [QW-1:0] mul_x;
      logic [DW-1:0] mul_y;
      logic [DW-1:0] den;
   } lfe_lane_type;

   typedef struct packed {
      logic [PW-1:0] prod;
      logic [DW-1:0] den;
      logic [QW-1:0] base;
      logic          neg;
   } lfe_prod_type;

   typedef struct packed {
      logic [DW-1:0] rem;
      logic [QW-1:0] low;
      logic [QW-1:0] quo;
      logic [DW-1:0] den;
      logic [QW-1:0] base;
      logic          neg;
   } lfe_div_type;

   // Dimming controls carried past the first pass.
   typedef struct packed {
      logic          dim_en;
      logic [DW-1:0] num;
      logic [QW-1:0] fade;
   } lfe_side_type;

endpackage

// File: rtl/lfe_setup.sv
// Input decode stage of the light fade envelope core: phase tests, saturated
// fractions and the lane set-up for the first pass. Depends on lfe_pkg.
module lfe_setup import lfe_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic signed [TW-1:0]       time_left,
   input  logic [QW-1:0]              fade_ms,
   input  logic [QW-1:0]              peak_ms,
   input  logic [QW-1:0]              full_radius,
   input  logic [QW-1:0]              start_radius,
   input  logic [QW-1:0]              color_r,
   input  logic [QW-1:0]              color_g,
   input  logic [QW-1:0]              color_b,
   input  logic [QW-1:0]              start_r,
   input  logic [QW-1:0]              start_g,
   input  logic [QW-1:0]              start_b,
   input  logic [FW-1:0]              mode_flags,
   output logic                       out_valid,
   output lfe_lane_type [LANES-1:0]   out_lane,
   output lfe_side_type               out_side
);

   logic                     valid_ff;
   lfe_lane_type [LANES-1:0] lane_ff, lane_in;
   lfe_side_type             side_ff, side_in;

   function automatic logic [DW-1:0] clamp_num(logic signed [XW-1:0] v, logic [DW-1:0] cap);
      logic signed [XW-1:0] cap_x;
      cap_x = signed'({{(XW-DW){1'b0}}, cap});
      if (v < 0) begin
         return '0;
      end else if (v > cap_x) begin
         return cap;
      end else begin
         return v[DW-1:0];
      end
   endfunction

   function automatic lfe_lane_type const_lane(logic [QW-1:0] v);
      lfe_lane_type l;
      l.base  = v;
      l.neg   = 1'b0;
      l.mul_x = '0;
      l.mul_y = '0;
      l.den   = DW'(1);
      return l;
   endfunction

   function automatic lfe_lane_type blend_lane(logic [QW-1:0] a, logic [QW-1:0] b,
                                               logic [DW-1:0] num, logic [DW-1:0] den);
      lfe_lane_type l;
      l.base  = a;
      l.neg   = (b < a);
      l.mul_x = l.neg ? (a - b) : (b - a);
      l.mul_y = num;
      l.den   = den;
      return l;
   endfunction

   always_comb begin
      logic [DW-1:0]        total;
      logic signed [XW-1:0] rem_x;
      logic signed [XW-1:0] fade_x;
      logic signed [XW-1:0] diff;
      logic                 rem_gt_fade;
      logic                 rem_lt_fade;
      logic [DW-1:0]        num_exp;
      logic [DW-1:0]        num_pk;
      logic [DW-1:0]        num_fd;
      logic                 expand;
      logic                 shrink;
      logic                 flash;
      logic [QW-1:0]        tgt [LANES];
      logic [QW-1:0]        ini [LANES];

      total       = {1'b0, fade_ms} + {1'b0, peak_ms};
      rem_x       = {{(XW-TW){time_left[TW-1]}}, time_left};
      fade_x      = signed'({{(XW-QW){1'b0}}, fade_ms});
      // Time since birth; the peak phase numerator is the same difference.
      diff        = signed'({{(XW-DW){1'b0}}, total}) - rem_x;
      rem_gt_fade = (rem_x > fade_x);
      rem_lt_fade = (rem_x < fade_x);
      num_exp     = clamp_num(diff, total);
      num_pk      = clamp_num(diff, {1'b0, peak_ms});
      num_fd      = clamp_num(rem_x, {1'b0, fade_ms});
      expand      = mode_flags[FLAG_EXPAND];
      shrink      = mode_flags[FLAG_SHRINK];
      flash       = mode_flags[FLAG_FLASH];

      tgt[LANE_RAD] = full_radius;
      ini[LANE_RAD] = start_radius;
      tgt[LANE_R]   = color_r;
      tgt[LANE_G]   = color_g;
      tgt[LANE_B]   = color_b;
      ini[LANE_R]   = start_r;
      ini[LANE_G]   = start_g;
      ini[LANE_B]   = start_b;

      if (total == '0) begin
         lane_in[LANE_RAD] = const_lane(full_radius);
      end else if (expand) begin
         lane_in[LANE_RAD] = blend_lane(start_radius, full_radius, num_exp, total);
      end else if (rem_gt_fade) begin
         if (peak_ms == '0) begin
            lane_in[LANE_RAD] = const_lane(start_radius);
         end else begin
            lane_in[LANE_RAD] = blend_lane(start_radius, full_radius, num_pk, {1'b0, peak_ms});
         end
      end else if (shrink) begin
         if (fade_ms == '0) begin
            lane_in[LANE_RAD] = const_lane('0);
         end else begin
            lane_in[LANE_RAD] = blend_lane('0, full_radius, num_fd, {1'b0, fade_ms});
         end
      end else begin
         lane_in[LANE_RAD] = const_lane(full_radius);
      end

      for (int l = LANE_R; l < LANES; l++) begin
         if (flash || peak_ms == '0 || !rem_gt_fade) begin
            lane_in[l] = const_lane(tgt[l]);
         end else begin
            lane_in[l] = blend_lane(ini[l], tgt[l], num_pk, {1'b0, peak_ms});
         end
      end

      side_in.dim_en = !flash && (fade_ms != '0) && rem_lt_fade;
      side_in.num    = num_fd;
      side_in.fade   = fade_ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/lfe_mad.sv
// Four-lane pipelined evaluator of base +/- (x * y) / den: a multiply stage,
// one restoring division stage per quotient bit and an add stage. Depends on lfe_pkg.
module lfe_mad import lfe_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  lfe_lane_type [LANES-1:0]       in_lane,
   input  lfe_side_type                   in_side,
   output logic                           out_valid,
   output logic [LANES-1:0][QW-1:0]       out_res,
   output lfe_side_type                   out_side
);

   logic [MAD_DEPTH-1:0]      vld_ff, vld_in;
   lfe_side_type              side_ff [MAD_DEPTH];
   lfe_side_type              side_in [MAD_DEPTH];
   lfe_prod_type [LANES-1:0]  prod_ff, prod_in;
   lfe_div_type [LANES-1:0]   div_ff [DIV_STEPS];
   lfe_div_type [LANES-1:0]   div_in [DIV_STEPS];
   logic [LANES-1:0][QW-1:0]  res_ff, res_in;

   function automatic lfe_div_type div_init(lfe_prod_type p);
      lfe_div_type d;
      // The quotient fits in QW bits because the numerator never exceeds den.
      d.rem  = p.prod[PW-1:QW];
      d.low  = p.prod[QW-1:0];
      d.quo  = '0;
      d.den  = p.den;
      d.base = p.base;
      d.neg  = p.neg;
      return d;
   endfunction

   function automatic lfe_div_type div_step(lfe_div_type cur);
      lfe_div_type nxt;
      logic [DW:0] trial;
      nxt   = cur;
      trial = {cur.rem, cur.low[QW-1]};
      if (trial >= {1'b0, cur.den}) begin
         nxt.rem = DW'(trial - {1'b0, cur.den});
         nxt.quo = {cur.quo[QW-2:0], 1'b1};
      end else begin
         nxt.rem = trial[DW-1:0];
         nxt.quo = {cur.quo[QW-2:0], 1'b0};
      end
      nxt.low = {cur.low[QW-2:0], 1'b0};
      return nxt;
   endfunction

   always_comb begin
      vld_in     = {vld_ff[MAD_DEPTH-2:0], in_valid};
      side_in[0] = in_side;
      for (int s = 1; s < MAD_DEPTH; s++) begin
         side_in[s] = side_ff[s-1];
      end

      for (int l = 0; l < LANES; l++) begin
         prod_in[l].prod = PW'(in_lane[l].mul_x) * PW'(in_lane[l].mul_y);
         prod_in[l].den  = in_lane[l].den;
         prod_in[l].base = in_lane[l].base;
         prod_in[l].neg  = in_lane[l].neg;
      end

      for (int l = 0; l < LANES; l++) begin
         div_in[0][l] = div_step(div_init(prod_ff[l]));
      end
      for (int s = 1; s < DIV_STEPS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            div_in[s][l] = div_step(div_ff[s-1][l]);
         end
      end

      // A blend never passes its end point, so the sum stays within QW bits.
      for (int l = 0; l < LANES; l++) begin
         if (div_ff[DIV_STEPS-1][l].neg) begin
            res_in[l] = div_ff[DIV_STEPS-1][l].base - div_ff[DIV_STEPS-1][l].quo;
         end else begin
            res_in[l] = div_ff[DIV_STEPS-1][l].base + div_ff[DIV_STEPS-1][l].quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         prod_ff <= prod_in;
         div_ff  <= div_in;
         res_ff  <= res_in;
      end
   end

   assign out_valid = vld_ff[MAD_DEPTH-1];
   assign out_res   = res_ff;
   assign out_side  = side_ff[MAD_DEPTH-1];

endmodule

// File: rtl/lfe_dim.sv
// Second-pass lane set-up: with dim_en set, scales each base colour
// by the fade fraction; passes the radius through. Depends on lfe_pkg.
module lfe_dim import lfe_pkg::*; (
   input  logic [LANES-1:0][QW-1:0]   in_res,
   input  lfe_side_type               in_side,
   output lfe_lane_type [LANES-1:0]   out_lane
);

   always_comb begin
      out_lane[LANE_RAD].base  = in_res[LANE_RAD];
      out_lane[LANE_RAD].neg   = 1'b0;
      out_lane[LANE_RAD].mul_x = '0;
      out_lane[LANE_RAD].mul_y = '0;
      out_lane[LANE_RAD].den   = DW'(1);

      for (int l = LANE_R; l < LANES; l++) begin
         out_lane[l].neg = 1'b0;
         if (in_side.dim_en) begin
            out_lane[l].base  = '0;
            out_lane[l].mul_x = in_res[l];
            out_lane[l].mul_y = in_side.num;
            out_lane[l].den   = {1'b0, in_side.fade};
         end else begin
            out_lane[l].base  = in_res[l];
            out_lane[l].mul_x = '0;
            out_lane[l].mul_y = '0;
            out_lane[l].den   = DW'(1);
         end
      end
   end

endmodule

// File: rtl/light_fade_envelope_core.sv
// Top level of the light fade envelope core: decode, blend pass, dimming pass.
// Depends on lfe_pkg, lfe_setup, lfe_mad and lfe_dim.
//
// Evaluates one dynamic light per beat: from its time left, phase lengths,
// radii, colours and mode flags it returns the current radius and colour.
// A new beat is taken in every cycle unless the pipeline is held; each result
// goes through one decode stage plus two passes of 18 stages each, where each
// pass is a multiply stage, a 16-stage restoring divider (one quotient bit per
// stage) and an add stage. The whole pipeline holds while a result is stalled,
// so req_stall rises only when rsp_valid and rsp_stall are both high. The core
// keeps no state between lights.
module light_fade_envelope_core import lfe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [TW-1:0] req_time_left,
   input  logic [QW-1:0]        req_fade_ms,
   input  logic [QW-1:0]        req_peak_ms,
   input  logic [QW-1:0]        req_full_radius,
   input  logic [QW-1:0]        req_start_radius,
   input  logic [QW-1:0]        req_color_r,
   input  logic [QW-1:0]        req_color_g,
   input  logic [QW-1:0]        req_color_b,
   input  logic [QW-1:0]        req_start_r,
   input  logic [QW-1:0]        req_start_g,
   input  logic [QW-1:0]        req_start_b,
   input  logic [FW-1:0]        req_mode_flags,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [QW-1:0]        rsp_cur_radius,
   output logic [QW-1:0]        rsp_cur_r,
   output logic [QW-1:0]        rsp_cur_g,
   output logic [QW-1:0]        rsp_cur_b
);

   logic                     en;
   logic                     setup_valid;
   lfe_lane_type [LANES-1:0] setup_lane;
   lfe_side_type             setup_side;
   logic                     blend_valid;
   logic [LANES-1:0][QW-1:0] blend_res;
   lfe_side_type             blend_side;
   lfe_lane_type [LANES-1:0] dim_lane;
   logic [LANES-1:0][QW-1:0] final_res;

   // Every stage advances together unless a finished result is held.
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   lfe_setup u_setup (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .time_left    (req_time_left),
      .fade_ms      (req_fade_ms),
      .peak_ms      (req_peak_ms),
      .full_radius  (req_full_radius),
      .start_radius (req_start_radius),
      .color_r      (req_color_r),
      .color_g      (req_color_g),
      .color_b      (req_color_b),
      .start_r      (req_start_r),
      .start_g      (req_start_g),
      .start_b      (req_start_b),
      .mode_flags   (req_mode_flags),
      .out_valid    (setup_valid),
      .out_lane     (setup_lane),
      .out_side     (setup_side)
   );

   lfe_mad u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (setup_valid),
      .in_lane   (setup_lane),
      .in_side   (setup_side),
      .out_valid (blend_valid),
      .out_res   (blend_res),
      .out_side  (blend_side)
   );

   lfe_dim u_dim (
      .in_res   (blend_res),
      .in_side  (blend_side),
      .out_lane (dim_lane)
   );

   lfe_mad u_fade (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (blend_valid),
      .in_lane   (dim_lane),
      .in_side   ('0),
      .out_valid (rsp_valid),
      .out_res   (final_res),
      .out_side  ()
   );

   assign rsp_cur_radius = final_res[LANE_RAD];
   assign rsp_cur_r      = final_res[LANE_R];
   assign rsp_cur_g      = final_res[LANE_G];
   assign rsp_cur_b      = final_res[LANE_B];

endmodule

// File: rtl/lfe_check.sv
// Port-level checks for the light fade envelope core, bound to the top level.
// Depends on lfe_pkg and light_fade_envelope_core.
module lfe_check import lfe_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input logic [QW-1:0] rsp_cur_radius,
   input logic [QW-1:0] rsp_cur_r,
   input logic [QW-1:0] rsp_cur_g,
   input logic [QW-1:0] rsp_cur_b
);

   // A held result beat stays valid.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A held result beat keeps its payload.
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_cur_radius) && $stable(rsp_cur_r) &&
                                 $stable(rsp_cur_g) && $stable(rsp_cur_b))
      else $error("result payload changed while stalled");

   // The core only pushes back on requests when its result is held.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held result");

   // The pipeline is empty right after reset.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind light_fade_envelope_core lfe_check u_lfe_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_cur_radius (rsp_cur_radius),
   .rsp_cur_r      (rsp_cur_r),
   .rsp_cur_g      (rsp_cur_g),
   .rsp_cur_b      (rsp_cur_b)
);
